// ===== design/dma_mapping_tracker_defines.svh =====
// Assertion macros used by the dma_mapping_tracker checker.
`ifndef DMA_MAPPING_TRACKER_DEFINES_SVH
`define DMA_MAPPING_TRACKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmt check failed");

// next-cycle implication, disabled while in reset
`define DMT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmt check failed");

`endif

// ===== design/dmt_pkg.sv =====
// Shared constants, codes and types of the DMA mapping tracker.
package dmt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 32;
    localparam int DEVICE_BITS   = 8;
    localparam int LEN_W         = ADDR_BITS + 1;
    localparam int END_W         = ADDR_BITS + 2;
    localparam int CMD_W         = 2;
    localparam int DIR_W         = 2;
    localparam int ALIGN_W       = 4;
    localparam int STATUS_W      = 2;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(6);

    // register select is paddr[2]
    localparam logic REG_ALIGN_LOG2 = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP      = 2'd0,
        CMD_UNMAP    = 2'd1,
        CMD_SYNC_CPU = 2'd2,
        CMD_SYNC_DEV = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_DUPLICATE  = 2'd1,
        STS_NOT_MAPPED = 2'd2,
        STS_TABLE_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [DEVICE_BITS-1:0] device;
        logic [ADDR_BITS-1:0]   start;
        logic [LEN_W-1:0]       length;
        logic [END_W-1:0]       end_addr;   // start + length, no wrap
        logic [DIR_W-1:0]       dir;
    } slot_data_t;

    typedef struct packed {
        logic compare;   // latch range relation against the request
        logic insert;    // take the lower neighbor's slot (map)
        logic remove;    // take the upper neighbor's slot at/after the hit (unmap)
    } cell_ctl_t;

    typedef struct packed {
        logic found;
        logic partial;
        logic size_mm;
        logic dir_mm;
    } chain_t;

endpackage

// ===== design/dmt_cell.sv =====
// One table slot: holds a mapping, compares it to the request and shifts with neighbors.
module dmt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dmt_pkg::cell_ctl_t ctl,
    input  dmt_pkg::slot_data_t req,
    input  logic               prev_valid,
    input  dmt_pkg::slot_data_t prev_data,
    input  logic               next_valid,
    input  dmt_pkg::slot_data_t next_data,
    input  dmt_pkg::chain_t    chain_in,
    output dmt_pkg::chain_t    chain_out,
    output logic               valid,
    output dmt_pkg::slot_data_t data
);
    import dmt_pkg::*;

    logic       valid_reg, valid_next;
    slot_data_t data_reg, data_next;
    logic       contained_reg, partial_reg, len_eq_reg, dir_eq_reg;

    logic dev_eq, contained_cmp, overlap_cmp, hit;

    always_comb
    begin
        dev_eq        = (data_reg.device == req.device);
        contained_cmp = valid_reg && dev_eq && (data_reg.start <= req.start)
                        && (req.end_addr <= data_reg.end_addr);
        overlap_cmp   = valid_reg && dev_eq
                        && ({2'b00, req.start} < data_reg.end_addr)
                        && ({2'b00, data_reg.start} < req.end_addr);
    end

    // priority chain: first containing slot from the newest end wins
    always_comb
    begin
        hit               = contained_reg && !chain_in.found;
        chain_out.found   = chain_in.found || contained_reg;
        chain_out.partial = chain_in.partial || (partial_reg && !chain_in.found);
        chain_out.size_mm = chain_in.size_mm || (hit && !len_eq_reg);
        chain_out.dir_mm  = chain_in.dir_mm || (hit && !dir_eq_reg);
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.insert)
        begin
            valid_next = prev_valid;
            data_next  = prev_data;
        end
        else if (ctl.remove && chain_out.found)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            contained_reg <= 1'b0;
            partial_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.compare)
            begin
                contained_reg <= contained_cmp;
                partial_reg   <= overlap_cmp && !contained_cmp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.compare)
        begin
            len_eq_reg <= (data_reg.length == req.length);
            dir_eq_reg <= (data_reg.dir == req.dir);
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== design/dma_mapping_tracker.sv =====
// Top level of the DMA mapping tracker: request latch, cell row, control and result register.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_stall  | cmd, device_id, bus_addr, length, dir
//   out     | output    | out_valid / out_stall| status, partial_overlap, size_mismatch,
//           |           |                      | dir_mismatch, misaligned, null_device
//   apb     | config    | psel/penable/pready  | align_log2 at byte address 0
//
// One word in flight: accept, compare cycle in every cell, then the update cycle that
// resolves the priority chain along the row, shifts the table and loads the result.
// out_valid rises as the state returns to idle, so the next word can be taken while the result is shown.
// in_stall is high from accept until the update; the update waits while a held result
// is stalled. Reset empties the table and sets align_log2 to 6.
module dma_mapping_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmt_pkg::APB_AW-1:0]        paddr,
    input  logic [dmt_pkg::APB_DW-1:0]        pwdata,
    output logic [dmt_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dmt_pkg::CMD_W-1:0]         cmd,
    input  logic [dmt_pkg::DEVICE_BITS-1:0]   device_id,
    input  logic [dmt_pkg::ADDR_BITS-1:0]     bus_addr,
    input  logic [dmt_pkg::LEN_W-1:0]         length,
    input  logic [dmt_pkg::DIR_W-1:0]         dir,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dmt_pkg::STATUS_W-1:0]      status,
    output logic                              partial_overlap,
    output logic                              size_mismatch,
    output logic                              dir_mismatch,
    output logic                              misaligned,
    output logic                              null_device
);
    import dmt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ALIGN_W-1:0] align_reg;
    logic [CMD_W-1:0]   cmd_reg;
    slot_data_t         req_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                partial_reg, size_mm_reg, dir_mm_reg, misaligned_reg, null_dev_reg;

    logic accept, commit, cfg_write;
    logic [LEN_W-1:0] len_norm;
    logic [ADDR_BITS-1:0] align_mask;
    logic [STATUS_W-1:0] status_calc;
    logic misaligned_calc;
    cell_ctl_t ctl;

    logic       cell_valid [TABLE_ENTRIES];
    slot_data_t cell_data  [TABLE_ENTRIES];
    chain_t     chain      [TABLE_ENTRIES+1];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ALIGN_LOG2)
            prdata = APB_DW'(align_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            align_reg <= ALIGN_RESET;
        else if (cfg_write && paddr[2] == REG_ALIGN_LOG2)
            align_reg <= pwdata[ALIGN_W-1:0];
    end

    // control
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign commit   = (state_reg == ST_UPD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request latch; zero length counts as one byte
    assign len_norm = (length == '0) ? LEN_W'(1) : length;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg          <= cmd;
            req_reg.device   <= device_id;
            req_reg.start    <= bus_addr;
            req_reg.length   <= len_norm;
            req_reg.end_addr <= END_W'(bus_addr) + END_W'(len_norm);
            req_reg.dir      <= dir;
        end
    end

    // cell row
    assign chain[0] = '0;

    always_comb
    begin
        ctl.compare = (state_reg == ST_CMP);
        ctl.insert  = commit && (cmd_reg == CMD_MAP) && !chain[TABLE_ENTRIES].found
                      && !cell_valid[TABLE_ENTRIES-1];
        ctl.remove  = commit && (cmd_reg == CMD_UNMAP) && chain[TABLE_ENTRIES].found;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic       prev_valid, next_valid;
        slot_data_t prev_data, next_data;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
            assign prev_data  = req_reg;
        end
        else
        begin : g_mid_prev
            assign prev_valid = cell_valid[i-1];
            assign prev_data  = cell_data[i-1];
        end

        if (i == TABLE_ENTRIES - 1)
        begin : g_last
            assign next_valid = 1'b0;
            assign next_data  = '0;
        end
        else
        begin : g_mid_next
            assign next_valid = cell_valid[i+1];
            assign next_data  = cell_data[i+1];
        end

        dmt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .req        (req_reg),
            .prev_valid (prev_valid),
            .prev_data  (prev_data),
            .next_valid (next_valid),
            .next_data  (next_data),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .valid      (cell_valid[i]),
            .data       (cell_data[i])
        );
    end

    // result
    assign align_mask = ~({ADDR_BITS{1'b1}} << align_reg);

    always_comb
    begin
        misaligned_calc = 1'b0;
        if (cmd_reg == CMD_MAP)
        begin
            if (chain[TABLE_ENTRIES].found)
                status_calc = STS_DUPLICATE;
            else if (cell_valid[TABLE_ENTRIES-1])
                status_calc = STS_TABLE_FULL;
            else
            begin
                status_calc     = STS_OK;
                misaligned_calc = ((req_reg.start & align_mask) != '0);
            end
        end
        else if (!chain[TABLE_ENTRIES].found)
            status_calc = STS_NOT_MAPPED;
        else
            status_calc = STS_OK;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg     <= status_calc;
            partial_reg    <= chain[TABLE_ENTRIES].partial;
            size_mm_reg    <= (cmd_reg == CMD_UNMAP) && chain[TABLE_ENTRIES].size_mm;
            dir_mm_reg     <= (cmd_reg == CMD_UNMAP) && chain[TABLE_ENTRIES].dir_mm;
            misaligned_reg <= misaligned_calc;
            null_dev_reg   <= (req_reg.device == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign partial_overlap = partial_reg;
    assign size_mismatch   = size_mm_reg;
    assign dir_mismatch    = dir_mm_reg;
    assign misaligned      = misaligned_reg;
    assign null_device     = null_dev_reg;

endmodule

// ===== design/dmt_checker.sv =====
// Port-level checks of the DMA mapping tracker, bound to the top level.
`include "dma_mapping_tracker_defines.svh"

module dmt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [dmt_pkg::STATUS_W-1:0] status,
    input logic                         size_mismatch,
    input logic                         dir_mismatch,
    input logic                         misaligned
);
    import dmt_pkg::*;

    // one word at a time: busy right after an accept
    `DMT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a fresh result follows its accept through the compare and update states
    `DMT_ASSERT_IMP(a_result_latency, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 3))

    // flags only accompany a successful map or unmap, never both kinds
    `DMT_ASSERT_IMP(a_flags_consistent, clk, rst_n, out_valid, (status == STS_OK || (!misaligned && !size_mismatch && !dir_mismatch)) && !(misaligned && (size_mismatch || dir_mismatch)))

    // a stalled result word holds
    `DMT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind dma_mapping_tracker dmt_checker u_dmt_checker (.*);
